/* rtl/core/bba_pkg.sv */
`timescale 1ns / 1ps
// Package for the block bitmap allocator: sizes, mode and state codes,
// and the small helper functions used by the top level. No dependencies.
package bba_pkg;

    localparam int BITMAP_BYTES = 1024;
    localparam int BYTE_BITS    = 8;
    localparam int WORD_BYTES   = 8;
    localparam int WORD_BITS    = WORD_BYTES * BYTE_BITS;
    localparam int WORDS        = (BITMAP_BYTES + WORD_BYTES - 1) / WORD_BYTES;
    localparam int WORD_AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BIT_AW       = $clog2(WORD_BITS);
    localparam int LANE_AW      = $clog2(WORD_BYTES);
    localparam int NUM_W        = 14;
    localparam int BYTE_W       = 8;

    localparam int RAW_CAPACITY = BITMAP_BYTES * BYTE_BITS;
    localparam int COUNT_MAX    = (1 << NUM_W) - 1;
    localparam logic [NUM_W-1:0] CAPACITY =
        NUM_W'((RAW_CAPACITY > COUNT_MAX) ? COUNT_MAX : RAW_CAPACITY);

    // Bytes of the last word that lie beyond the bitmap read as in use.
    localparam int LAST_BYTES = BITMAP_BYTES - (WORDS - 1) * WORD_BYTES;
    localparam logic [WORD_BITS-1:0] LAST_PAD = (LAST_BYTES == WORD_BYTES) ? '0 :
        ~((WORD_BITS'(1) << (LAST_BYTES * BYTE_BITS)) - WORD_BITS'(1));

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_LOAD  = 2'd2,
        MODE_SET   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_MODIFY,
        S_WRITE
    } t_state;

    // Write-back notice from the sequencer to the summary flags.
    typedef struct packed {
        logic               we;
        logic [WORD_AW-1:0] addr;
        logic               full;
    } t_sum_upd;

    // Summary status seen by the sequencer.
    typedef struct packed {
        logic               any_free;
        logic [WORD_AW-1:0] first;
        logic               valid;
    } t_sum_stat;

    function automatic logic [WORD_BITS-1:0] word_pad(input logic [WORD_AW-1:0] addr);
        return (addr == WORD_AW'(WORDS - 1)) ? LAST_PAD : '0;
    endfunction

    // Index of the lowest clear bit; the caller knows one exists.
    function automatic logic [BIT_AW-1:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_AW-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                idx = BIT_AW'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* rtl/core/bba_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the block bitmap allocator.
// Depends on bba_pkg for the field widths.
interface bba_in_if;
    import bba_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [NUM_W-1:0]  number;
    logic [BYTE_W-1:0] load_byte;

    modport source (output valid, output mode, output number, output load_byte,
                    input ready);
    modport sink   (input valid, input mode, input number, input load_byte,
                    output ready);
endinterface

interface bba_out_if;
    import bba_pkg::*;
    logic             valid;
    logic             ready;
    logic [NUM_W-1:0] allocated;
    logic             ok;
    logic [NUM_W-1:0] free_count;

    modport source (output valid, output allocated, output ok, output free_count,
                    input ready);
    modport sink   (input valid, input allocated, input ok, input free_count,
                    output ready);
endinterface

/* rtl/core/bba_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/bba_summary.sv */
`timescale 1ns / 1ps
// Per-word written and full flags of the bitmap, with the first-fit word search.
// Depends on bba_pkg.
module bba_summary import bba_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_sum_upd           i_upd,
    input  logic [WORD_AW-1:0] i_addr,
    output t_sum_stat          o_stat
);

    logic [WORDS-1:0] r_valid;
    logic [WORDS-1:0] r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_full  <= '0;
        end else if (i_upd.we) begin
            r_valid[i_upd.addr] <= 1'b1;
            r_full[i_upd.addr]  <= i_upd.full;
        end
    end

    // A word never written holds all zero, so it is never full.
    always_comb begin
        o_stat.any_free = ~&r_full;
        o_stat.first    = '0;
        for (int i = WORDS - 1; i >= 0; i--) begin
            if (!r_full[i]) begin
                o_stat.first = WORD_AW'(i);
            end
        end
        o_stat.valid = r_valid[i_addr];
    end

endmodule

/* rtl/core/block_bitmap_allocator.sv */
`timescale 1ns / 1ps
// Top level of the first-fit block bitmap allocator.
// Depends on bba_pkg, bba_if, bba_ram and bba_summary.
//
//  Channel  Dir  Fields                         Meaning
//  i_in     in   mode, number, load_byte        allocate, free, load byte, set count
//  o_out    out  allocated, ok, free_count      one result item per input item
//
// Every item passes through accept, read issue, read-modify and write-back, in order.
// The order is set by the single bitmap RAM, whose registered read data
// sits between the address choice and the modified word.
// Reset clears the per-word written flags at once, so no clearing pass runs:
// an unwritten word reads as zero. The free count resets to zero.
// A stalled output holds the item in the write-back state; a new item can be
// accepted while the previous result still waits in the output register.
module block_bitmap_allocator import bba_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bba_in_if.sink     i_in,
    bba_out_if.source  o_out
);

    t_state r_state, n_state;

    // Item latched at acceptance.
    t_mode             r_mode, n_mode;
    logic [NUM_W-1:0]  r_num, n_num;
    logic [BYTE_W-1:0] r_lbyte, n_lbyte;

    // Working registers of the read-modify-write.
    logic [WORD_AW-1:0]   r_addr, n_addr;
    logic                 r_ok, n_ok;
    logic [BIT_AW-1:0]    r_bit, n_bit;
    logic [WORD_BITS-1:0] r_wdata, n_wdata;

    logic [NUM_W-1:0] r_count, n_count;

    // Output register.
    logic             r_out_valid, n_out_valid;
    logic [NUM_W-1:0] r_allocated, n_allocated;
    logic             r_out_ok, n_out_ok;
    logic [NUM_W-1:0] r_free_count, n_free_count;

    logic [WORD_BITS-1:0] rdata;
    logic [WORD_BITS-1:0] rword;
    logic [WORD_AW-1:0]   raddr;
    logic [NUM_W-1:0]     nm1;
    logic                 out_free;
    t_sum_upd             upd;
    t_sum_stat            stat;

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (upd.we),
        .i_waddr (upd.addr),
        .i_wdata (r_wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    bba_summary u_summary (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (upd),
        .i_addr  (r_addr),
        .o_stat  (stat)
    );

    assign nm1      = r_num - NUM_W'(1);
    assign out_free = !r_out_valid || o_out.ready;
    // Words never written read as zero; the summary looks up r_addr.
    assign rword    = stat.valid ? rdata : '0;

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.allocated  = r_allocated;
    assign o_out.ok         = r_out_ok;
    assign o_out.free_count = r_free_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_num        <= n_num;
        r_lbyte      <= n_lbyte;
        r_addr       <= n_addr;
        r_ok         <= n_ok;
        r_bit        <= n_bit;
        r_wdata      <= n_wdata;
        r_allocated  <= n_allocated;
        r_out_ok     <= n_out_ok;
        r_free_count <= n_free_count;
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_num        = r_num;
        n_lbyte      = r_lbyte;
        n_addr       = r_addr;
        n_ok         = r_ok;
        n_bit        = r_bit;
        n_wdata      = r_wdata;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_allocated  = r_allocated;
        n_out_ok     = r_out_ok;
        n_free_count = r_free_count;
        raddr        = r_addr;
        upd.we       = 1'b0;
        upd.addr     = r_addr;
        upd.full     = &(r_wdata | word_pad(r_addr));

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_mode  = t_mode'(i_in.mode);
                    n_num   = i_in.number;
                    n_lbyte = i_in.load_byte;
                    n_state = S_ISSUE;
                end
            end

            // Pick the word and start its read; decide whether the item succeeds.
            S_ISSUE: begin
                case (r_mode)
                    MODE_ALLOC: begin
                        n_addr = stat.first;
                        n_ok   = stat.any_free;
                    end
                    MODE_FREE: begin
                        n_addr = WORD_AW'(nm1 >> BIT_AW);
                        n_ok   = (r_num != '0) && (32'(r_num) <= RAW_CAPACITY);
                    end
                    MODE_LOAD: begin
                        n_addr = WORD_AW'(r_num >> LANE_AW);
                        n_ok   = 32'(r_num) < BITMAP_BYTES;
                    end
                    default: begin
                        n_ok = 1'b1;
                    end
                endcase
                raddr   = n_addr;
                n_state = S_MODIFY;
            end

            // Read data is here: build the new word.
            S_MODIFY: begin
                n_wdata = rword;
                case (r_mode)
                    MODE_ALLOC: begin
                        n_bit = first_zero(rword | word_pad(r_addr));
                        n_wdata[n_bit] = 1'b1;
                    end
                    MODE_FREE: begin
                        n_bit = nm1[BIT_AW-1:0];
                        n_wdata[n_bit] = 1'b0;
                    end
                    MODE_LOAD: begin
                        for (int j = 0; j < WORD_BYTES; j++) begin
                            if (r_num[LANE_AW-1:0] == LANE_AW'(j)) begin
                                n_wdata[j*BYTE_BITS +: BYTE_BITS] = r_lbyte;
                            end
                        end
                    end
                    default: begin
                        n_wdata = rword;
                    end
                endcase
                n_state = S_WRITE;
            end

            // Write back, update the count and hand over the result.
            S_WRITE: begin
                if (out_free) begin
                    upd.we = r_ok && (r_mode != MODE_SET);
                    n_allocated = '0;
                    case (r_mode)
                        MODE_ALLOC: begin
                            if (r_ok) begin
                                n_allocated = NUM_W'({r_addr, r_bit}) + NUM_W'(1);
                                if (r_count != '0) begin
                                    n_count = r_count - NUM_W'(1);
                                end
                            end
                        end
                        MODE_FREE: begin
                            if (r_ok && (r_count < CAPACITY)) begin
                                n_count = r_count + NUM_W'(1);
                            end
                        end
                        MODE_SET: begin
                            n_count = (r_num > CAPACITY) ? CAPACITY : r_num;
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                    n_out_ok     = r_ok;
                    n_free_count = n_count;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
